// File: rtl/core/rssi_diversity_selector_assert.svh
// ----------------------------------------------------------------------------
// RSSI diversity selector assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RSSI_DIVERSITY_SELECTOR_ASSERT_SVH
`define RSSI_DIVERSITY_SELECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RDS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rds: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RDS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rds: next-cycle check failed");

`endif

// File: rtl/core/rds_pkg.sv
// ----------------------------------------------------------------------------
// RSSI diversity selector package
// Field widths, register indexes, codes and shared structs.
// ----------------------------------------------------------------------------
package rds_pkg;

  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned LEVEL_W    = 7;
  localparam int unsigned DIFF_W     = 8;
  localparam int unsigned SEL_W      = 2;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CHECK_W    = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  // Numerator widths of the level and percent divisions.
  localparam int unsigned LEV_NUM_W  = 17;
  localparam int unsigned DIFF_NUM_W = 14;

  localparam int unsigned LEVEL_SPAN = 99;
  localparam int unsigned LEVEL_MAX  = 100;
  localparam int unsigned PERCENT    = 100;
  localparam int unsigned DIFF_MAX   = 255;

  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOVER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHECKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_A   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_A   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_B   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_B   = 3'd6;

  localparam logic [MODE_W-1:0] MODE_AUTO    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FORCE_A = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FORCE_B = 2'd2;

  localparam logic [SEL_W-1:0] SEL_A    = 2'd0;
  localparam logic [SEL_W-1:0] SEL_B    = 2'd1;
  localparam logic [SEL_W-1:0] SEL_NONE = 2'd2;

  localparam logic [MODE_W-1:0]     RST_MODE    = MODE_AUTO;
  localparam logic [DIFF_W-1:0]     RST_CUTOVER = 8'd10;
  localparam logic [CHECK_W-1:0]    RST_CHECKS  = 8'd2;
  localparam logic [SAMPLE_W-1:0]   RST_LOW     = 10'd0;
  localparam logic [SAMPLE_W-1:0]   RST_HIGH    = 10'd1023;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_a;
    logic [SAMPLE_W-1:0] sample_b;
  } in_req_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] average_a;
    logic [SAMPLE_W-1:0] average_b;
    logic [LEVEL_W-1:0]  level_a;
    logic [LEVEL_W-1:0]  level_b;
    logic [DIFF_W-1:0]   percent_diff;
    logic [SEL_W-1:0]    active_receiver;
    logic                led_a;
    logic                led_b;
  } out_req_t;

  // Lane status toward the top level and the merge stage.
  typedef struct packed {
    logic                ready;
    logic                done;
    logic [SAMPLE_W-1:0] avg;
    logic [LEVEL_W-1:0]  level;
  } lane_stat_t;

  typedef struct packed {
    logic idle;
    logic done;
  } merge_stat_t;

endpackage

// File: rtl/core/rds_div.sv
// ----------------------------------------------------------------------------
// RDS serial divider
// Restoring unsigned divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module rds_div #(
  parameter int unsigned NUM_W = 17,
  parameter int unsigned DEN_W = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int unsigned CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_dif;
  logic             ge;

  always_comb begin
    rem_sh   = {rem_r, quo_r[NUM_W-1]};
    ge       = (rem_sh >= {1'b0, den_r});
    rem_dif  = rem_sh - {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W - 1);
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      // The partial remainder stays below the divisor, so it fits DEN_W bits.
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      rem_nxt = ge ? rem_dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// File: rtl/core/rds_lane.sv
// ----------------------------------------------------------------------------
// RDS receiver lane
// Group accumulator, mean, calibration limit tracking and 1..100 level.
// ----------------------------------------------------------------------------
module rds_lane import rds_pkg::*; #(
  parameter int unsigned SAMPLES = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                lo_load,
  input  logic                hi_load,
  input  logic [SAMPLE_W-1:0] load_value,
  input  logic                ack,
  output lane_stat_t          stat
);

  localparam int unsigned CNT_W   = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int unsigned SUM_W   = SAMPLE_W + CNT_W;
  // The mean is a reciprocal multiplication. With the shift set to the sum
  // width plus the bits of SAMPLES and the multiplier rounded up, the
  // truncated product equals the truncated quotient for every sum that fits.
  localparam int unsigned AVG_SH  = SUM_W + $clog2(SAMPLES);
  localparam int unsigned AVG_M_W = SUM_W + 2;
  localparam int unsigned PROD_W  = SUM_W + AVG_M_W;
  localparam logic [AVG_M_W-1:0] AVG_M =
    AVG_M_W'(((64'd1 << AVG_SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES - 1);

  typedef enum logic [2:0] {
    L_IDLE,
    L_AVG,
    L_SCALE,
    L_LEV,
    L_DONE
  } lane_state_t;

  lane_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SAMPLE_W-1:0] lo_r, lo_nxt;
  logic [SAMPLE_W-1:0] hi_r, hi_nxt;
  logic [SAMPLE_W-1:0] avg_r, avg_nxt;
  logic [LEVEL_W-1:0]  level_r, level_nxt;

  logic [SUM_W-1:0]     sum_add;
  logic [PROD_W-1:0]    avg_prod;
  logic [SAMPLE_W-1:0]  avg_new;
  logic [SAMPLE_W-1:0]  span;
  logic [LEV_NUM_W-1:0] scaled;
  logic                 div_start;
  logic                 div_done;
  logic [LEV_NUM_W-1:0] div_quo;

  rds_div #(
    .NUM_W (LEV_NUM_W),
    .DEN_W (SAMPLE_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (scaled),
    .den   (span),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    sum_add   = sum_r + SUM_W'(sample);
    avg_prod  = PROD_W'(sum_r) * PROD_W'(AVG_M);
    avg_new   = avg_prod[AVG_SH +: SAMPLE_W];
    span      = hi_r - lo_r;
    scaled    = LEV_NUM_W'(avg_r - lo_r) * LEV_NUM_W'(LEVEL_SPAN);
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    avg_nxt   = avg_r;
    level_nxt = level_r;
    div_start = 1'b0;
    case (state_r)
      L_IDLE: begin
        if (acc) begin
          sum_nxt = sum_add;
          if (cnt_r == LAST_CNT) begin
            cnt_nxt   = '0;
            state_nxt = L_AVG;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      L_AVG: begin
        // The group total is complete; take the mean and clear the total.
        avg_nxt = avg_new;
        sum_nxt = '0;
        if (avg_new > hi_r) begin
          hi_nxt = avg_new;
        end
        if (avg_new < lo_r) begin
          lo_nxt = avg_new;
        end
        state_nxt = L_SCALE;
      end
      L_SCALE: begin
        // Widening keeps low <= mean <= high; equal limits give level one.
        if (hi_r <= lo_r) begin
          level_nxt = LEVEL_W'(1);
          state_nxt = L_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = L_LEV;
        end
      end
      L_LEV: begin
        if (div_done) begin
          level_nxt = div_quo[LEVEL_W-1:0] + 1'b1;
          state_nxt = L_DONE;
        end
      end
      L_DONE: begin
        if (ack) begin
          state_nxt = L_IDLE;
        end
      end
      default: begin
        state_nxt = L_IDLE;
      end
    endcase
    if (lo_load) begin
      lo_nxt = load_value;
    end
    if (hi_load) begin
      hi_nxt = load_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      cnt_r   <= '0;
      sum_r   <= '0;
      lo_r    <= RST_LOW;
      hi_r    <= RST_HIGH;
      avg_r   <= avg_nxt;
      level_r <= level_nxt;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
      avg_r   <= avg_nxt;
      level_r <= level_nxt;
    end
  end

  assign stat.ready = (state_r == L_IDLE);
  assign stat.done  = (state_r == L_DONE);
  assign stat.avg   = avg_r;
  assign stat.level = level_r;

endmodule

// File: rtl/core/rds_merge.sv
// ----------------------------------------------------------------------------
// RDS merge stage
// Combines both lanes: percent difference, hysteresis counter, selection.
// ----------------------------------------------------------------------------
module rds_merge import rds_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  lane_stat_t         lane_a,
  input  lane_stat_t         lane_b,
  input  logic [MODE_W-1:0]  mode,
  input  logic [DIFF_W-1:0]  cutover,
  input  logic [CHECK_W-1:0] max_checks,
  input  logic               take,
  output merge_stat_t        stat,
  output out_req_t           res
);

  typedef enum logic [1:0] {
    M_IDLE,
    M_DIV,
    M_DONE
  } merge_state_t;

  merge_state_t        state_r, state_nxt;
  logic [CHECK_W-1:0]  checks_r, checks_nxt;
  logic [SEL_W-1:0]    sel_r, sel_nxt;
  logic [SAMPLE_W-1:0] avg_a_r, avg_a_nxt;
  logic [SAMPLE_W-1:0] avg_b_r, avg_b_nxt;
  logic [LEVEL_W-1:0]  lev_a_r, lev_a_nxt;
  logic [LEVEL_W-1:0]  lev_b_r, lev_b_nxt;
  logic [DIFF_W-1:0]   diff_r, diff_nxt;

  logic [LEVEL_W-1:0]    lev_dist;
  logic                  div_start;
  logic [DIFF_NUM_W-1:0] div_num;
  logic                  div_done;
  logic [DIFF_NUM_W-1:0] div_quo;
  logic [DIFF_W-1:0]     diff_sat;
  logic [CHECK_W-1:0]    checks_upd;

  rds_div #(
    .NUM_W (DIFF_NUM_W),
    .DEN_W (LEVEL_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (lane_b.level),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    lev_dist = (lane_a.level > lane_b.level) ? (lane_a.level - lane_b.level)
                                             : (lane_b.level - lane_a.level);
    div_num  = DIFF_NUM_W'(lev_dist) * DIFF_NUM_W'(PERCENT);
    diff_sat = (div_quo > DIFF_NUM_W'(DIFF_MAX)) ? DIFF_W'(DIFF_MAX)
                                                 : div_quo[DIFF_W-1:0];
    // Step toward B when A is weaker, toward A when A is stronger.
    checks_upd = checks_r;
    if ((lev_a_r > lev_b_r) && (checks_r != '0)) begin
      checks_upd = checks_r - 1'b1;
    end
    if ((lev_a_r < lev_b_r) && (checks_r < max_checks)) begin
      checks_upd = checks_r + 1'b1;
    end

    state_nxt  = state_r;
    checks_nxt = checks_r;
    sel_nxt    = sel_r;
    avg_a_nxt  = avg_a_r;
    avg_b_nxt  = avg_b_r;
    lev_a_nxt  = lev_a_r;
    lev_b_nxt  = lev_b_r;
    diff_nxt   = diff_r;
    div_start  = 1'b0;
    case (state_r)
      M_IDLE: begin
        if (start) begin
          avg_a_nxt = lane_a.avg;
          avg_b_nxt = lane_b.avg;
          lev_a_nxt = lane_a.level;
          lev_b_nxt = lane_b.level;
          diff_nxt  = '0;
          case (mode)
            MODE_AUTO: begin
              div_start = 1'b1;
              state_nxt = M_DIV;
            end
            MODE_FORCE_A: begin
              sel_nxt   = SEL_A;
              state_nxt = M_DONE;
            end
            MODE_FORCE_B: begin
              sel_nxt   = SEL_B;
              state_nxt = M_DONE;
            end
            default: begin
              state_nxt = M_DONE;
            end
          endcase
        end
      end
      M_DIV: begin
        if (div_done) begin
          diff_nxt = diff_sat;
          if (diff_sat >= cutover) begin
            checks_nxt = checks_upd;
            if (checks_upd == '0) begin
              sel_nxt = SEL_A;
            end else if (checks_upd >= max_checks) begin
              sel_nxt = SEL_B;
            end
          end
          state_nxt = M_DONE;
        end
      end
      M_DONE: begin
        if (take) begin
          state_nxt = M_IDLE;
        end
      end
      default: begin
        state_nxt = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= M_IDLE;
      checks_r <= '0;
      sel_r    <= SEL_NONE;
      avg_a_r  <= avg_a_nxt;
      avg_b_r  <= avg_b_nxt;
      lev_a_r  <= lev_a_nxt;
      lev_b_r  <= lev_b_nxt;
      diff_r   <= diff_nxt;
    end else begin
      state_r  <= state_nxt;
      checks_r <= checks_nxt;
      sel_r    <= sel_nxt;
      avg_a_r  <= avg_a_nxt;
      avg_b_r  <= avg_b_nxt;
      lev_a_r  <= lev_a_nxt;
      lev_b_r  <= lev_b_nxt;
      diff_r   <= diff_nxt;
    end
  end

  assign stat.idle = (state_r == M_IDLE);
  assign stat.done = (state_r == M_DONE);

  assign res.average_a       = avg_a_r;
  assign res.average_b       = avg_b_r;
  assign res.level_a         = lev_a_r;
  assign res.level_b         = lev_b_r;
  assign res.percent_diff    = diff_r;
  assign res.active_receiver = sel_r;
  assign res.led_a           = (sel_r == SEL_A);
  assign res.led_b           = (sel_r == SEL_B);

endmodule

// File: rtl/core/rssi_diversity_selector.sv
// ----------------------------------------------------------------------------
// RSSI diversity selector. The last request of a group reaches its result
// through the mean by reciprocal multiply, a level division per lane, then a
// merge division. The input stalls after that request, and longer while a
// finished result waits. Synchronous active-low reset: limits to reset
// calibration, selection to none.
// ----------------------------------------------------------------------------
module rssi_diversity_selector import rds_pkg::*; #(
  parameter int unsigned SAMPLES = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_req_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_req_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers. The four calibration registers have no storage
  // here: a write loads the lane's tracked limit directly, which is all the
  // behavior ever sees of them.
  logic [MODE_W-1:0]  mode_r, mode_nxt;
  logic [DIFF_W-1:0]  cutover_r, cutover_nxt;
  logic [CHECK_W-1:0] checks_r, checks_nxt;

  // Output register, so a finished result can wait while the lanes keep
  // accumulating the next group.
  logic     out_valid_r, out_valid_nxt;
  out_req_t out_data_r, out_data_nxt;

  lane_stat_t  lane_a_stat;
  lane_stat_t  lane_b_stat;
  merge_stat_t merge_stat;
  out_req_t    merge_res;
  logic        in_acc;
  logic        merge_start;
  logic        out_take;

  // Range flags of the delivered levels, used by the checks at the end.
  logic        lev_a_ok;
  logic        lev_b_ok;

  // Both lanes step on the same request; either one may still be busy with
  // its divisions, so the input waits for both.
  assign in_ready = lane_a_stat.ready && lane_b_stat.ready;
  assign in_acc   = in_valid && in_ready;

  // The merge stage starts once both lanes hold a level and it is idle; the
  // start also releases both lanes.
  assign merge_start = lane_a_stat.done && lane_b_stat.done && merge_stat.idle;
  assign out_take    = !out_valid_r || out_ready;

  rds_lane #(
    .SAMPLES (SAMPLES)
  ) u_lane_a (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (in_acc),
    .sample     (in_data.sample_a),
    .lo_load    (cfg_we && (cfg_index == REG_MIN_A)),
    .hi_load    (cfg_we && (cfg_index == REG_MAX_A)),
    .load_value (cfg_wdata[SAMPLE_W-1:0]),
    .ack        (merge_start),
    .stat       (lane_a_stat)
  );

  rds_lane #(
    .SAMPLES (SAMPLES)
  ) u_lane_b (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (in_acc),
    .sample     (in_data.sample_b),
    .lo_load    (cfg_we && (cfg_index == REG_MIN_B)),
    .hi_load    (cfg_we && (cfg_index == REG_MAX_B)),
    .load_value (cfg_wdata[SAMPLE_W-1:0]),
    .ack        (merge_start),
    .stat       (lane_b_stat)
  );

  rds_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (merge_start),
    .lane_a     (lane_a_stat),
    .lane_b     (lane_b_stat),
    .mode       (mode_r),
    .cutover    (cutover_r),
    .max_checks (checks_r),
    .take       (out_take),
    .stat       (merge_stat),
    .res        (merge_res)
  );

  always_comb begin
    mode_nxt    = mode_r;
    cutover_nxt = cutover_r;
    checks_nxt  = checks_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_MODE:    mode_nxt    = cfg_wdata[MODE_W-1:0];
        REG_CUTOVER: cutover_nxt = cfg_wdata[DIFF_W-1:0];
        REG_CHECKS:  checks_nxt  = cfg_wdata[CHECK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A held result leaves when the consumer takes it; a new one loads in the
  // same cycle when the merge stage has one ready.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (merge_stat.done && out_take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = merge_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= RST_MODE;
      cutover_r   <= RST_CUTOVER;
      checks_r    <= RST_CHECKS;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      cutover_r   <= cutover_nxt;
      checks_r    <= checks_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign lev_a_ok = (out_data.level_a != '0) && (out_data.level_a <= LEVEL_W'(LEVEL_MAX));
  assign lev_b_ok = (out_data.level_b != '0) && (out_data.level_b <= LEVEL_W'(LEVEL_MAX));

  `include "rssi_diversity_selector_assert.svh"

  // The two indicators never light together.
  `RDS_ASSERT_IMP(a_led_excl, out_valid, !(out_data.led_a && out_data.led_b))
  // Delivered levels stay within the calibrated range of 1 to 100.
  `RDS_ASSERT_IMP(a_level_range, out_valid, lev_a_ok && lev_b_ok)
  // A lane holding a finished level takes no new request.
  `RDS_ASSERT_IMP(a_lane_hold, lane_a_stat.done || lane_b_stat.done, !in_ready)
  // A finished merge result with an empty output register is shown next cycle.
  `RDS_ASSERT_NXT(a_out_load, merge_stat.done && !out_valid, out_valid)

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSSI diversity selector testbench
// Sends pairs of receiver readings over a valid/ready channel and checks each
// group report against a cycle-free predictor of averaging, calibration,
// percent difference and hysteresis selection, under several register setups.
// ----------------------------------------------------------------------------
module tb_top;
  import rds_pkg::*;

  // Readings per averaging group; the block is built with the same value.
  localparam int GROUP_LEN = 8;

  // Quiet cycles after the last report before registers may be written again.
  localparam int SETTLE_CYCLES = 80;

  // Cycles without any accepted request before the run is declared hung. This
  // covers the long receiver hold-off, the settle wait and the group latency.
  localparam int WATCHDOG_LIMIT = 5000;

  // Length of the one long receiver hold-off that backs up the block.
  localparam int LONG_HOLD = 400;

  localparam int NUM_PHASES       = 12;
  localparam int GROUPS_PER_PHASE = 10;
  localparam int PRESSURE_PHASE   = 5;
  localparam int REPORT_LIMIT     = 10;

  // The unused encoding of the mode register; selection must hold in it.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  // Shapes of a random group of readings.
  localparam int SHAPE_A_WEAK   = 0;
  localparam int SHAPE_A_STRONG = 1;
  localparam int SHAPE_ALIKE    = 2;
  localparam int SHAPE_NOISE    = 3;

  // One row of the directed stimulus: either a register write or a run of
  // identical request pairs. A row with a known report carries it in want.
  typedef enum logic {
    STEP_WRITE,
    STEP_PAIRS
  } step_kind_e;

  typedef struct packed {
    step_kind_e                  kind;
    logic [CFG_IDX_W-1:0]        reg_idx;
    logic [CFG_DATA_W-1:0]       reg_val;
    in_req_t                     pair;
    logic [3:0]                  reps;
    logic                        typed;
    out_req_t                    want;
  } step_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_req_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_req_t              out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rssi_diversity_selector #(
    .SAMPLES (GROUP_LEN)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Group reports the predictor has produced and the block still owes, oldest
  // first.
  out_req_t due_reports[$];

  int  fail_count   = 0;
  int  stuck_cycles = 0;

  // Idle control. When calm is set neither side inserts gaps. The receiver's
  // short stall is drawn per report; hold_extra is the long hold-off.
  bit  calm         = 1'b0;
  int  stall_left   = 0;
  int  hold_extra   = 0;

  // --------------------------------------------------------------------------
  // Predictor state: register copies and the block's running state.
  // --------------------------------------------------------------------------
  logic [MODE_W-1:0]   mode_sel;
  logic [DIFF_W-1:0]   cut_pct;
  logic [CHECK_W-1:0]  check_max;
  logic [5:0]          fill;
  logic [15:0]         acc_a;
  logic [15:0]         acc_b;
  logic [SAMPLE_W-1:0] floor_a;
  logic [SAMPLE_W-1:0] ceil_a;
  logic [SAMPLE_W-1:0] floor_b;
  logic [SAMPLE_W-1:0] ceil_b;
  logic [CHECK_W-1:0]  tally;
  logic [SEL_W-1:0]    chosen;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Linear map of a mean onto 1..100 between the tracked limits. A window of
  // zero width (or a mean below the floor) reads as the weakest level.
  function automatic logic [LEVEL_W-1:0] scale_level(logic [SAMPLE_W-1:0] avg,
                                                     logic [SAMPLE_W-1:0] lo,
                                                     logic [SAMPLE_W-1:0] hi);
    int unsigned n;
    if (hi <= lo || avg < lo) begin
      return LEVEL_W'(1);
    end
    n = (avg - lo) * LEVEL_SPAN / (hi - lo) + 1;
    return n[LEVEL_W-1:0];
  endfunction

  // Folds one accepted pair into the running sums. On the last pair of a
  // group it closes the group and produces the report the block must send.
  task automatic absorb_pair(input in_req_t req, output bit closed,
                             output out_req_t rpt);
    logic [SAMPLE_W-1:0] mean_a;
    logic [SAMPLE_W-1:0] mean_b;
    logic [LEVEL_W-1:0]  lv_a;
    logic [LEVEL_W-1:0]  lv_b;
    int unsigned         spread;
    int unsigned         pct;
    acc_a  = acc_a + 16'(req.sample_a);
    acc_b  = acc_b + 16'(req.sample_b);
    rpt    = '0;
    closed = 1'b0;
    if (fill + 1 < GROUP_LEN) begin
      fill = fill + 1'b1;
    end else begin
      closed = 1'b1;
      mean_a = SAMPLE_W'(acc_a / GROUP_LEN);
      mean_b = SAMPLE_W'(acc_b / GROUP_LEN);
      fill   = '0;
      acc_a  = '0;
      acc_b  = '0;
      // The limits only ever widen, so afterwards they bracket the mean.
      if (mean_a > ceil_a) ceil_a = mean_a;
      if (mean_a < floor_a) floor_a = mean_a;
      if (mean_b > ceil_b) ceil_b = mean_b;
      if (mean_b < floor_b) floor_b = mean_b;
      lv_a = scale_level(mean_a, floor_a, ceil_a);
      lv_b = scale_level(mean_b, floor_b, ceil_b);
      pct  = 0;
      if (mode_sel == MODE_AUTO) begin
        spread = (lv_a > lv_b) ? lv_a - lv_b : lv_b - lv_a;
        pct    = spread * PERCENT / lv_b;
        if (pct > DIFF_MAX) pct = DIFF_MAX;
        if (pct >= cut_pct) begin
          if (lv_a > lv_b && tally > 0) tally = tally - 1'b1;
          if (lv_a < lv_b && tally < check_max) tally = tally + 1'b1;
          // A counter above a lowered maximum still counts as reached.
          if (tally == 0) begin
            chosen = SEL_A;
          end else if (tally >= check_max) begin
            chosen = SEL_B;
          end
        end
      end else if (mode_sel == MODE_FORCE_A) begin
        chosen = SEL_A;
      end else if (mode_sel == MODE_FORCE_B) begin
        chosen = SEL_B;
      end
      rpt.average_a       = mean_a;
      rpt.average_b       = mean_b;
      rpt.level_a         = lv_a;
      rpt.level_b         = lv_b;
      rpt.percent_diff    = pct[DIFF_W-1:0];
      rpt.active_receiver = chosen;
      rpt.led_a           = (chosen == SEL_A);
      rpt.led_b           = (chosen == SEL_B);
    end
  endtask

  // Drives one register write; the block takes it at the next rising edge.
  // The write enable stays high so that writes can follow back to back.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_MODE:    mode_sel  = val[MODE_W-1:0];
      REG_CUTOVER: cut_pct   = val[DIFF_W-1:0];
      REG_CHECKS:  check_max = val[CHECK_W-1:0];
      REG_MIN_A:   floor_a   = val;
      REG_MAX_A:   ceil_a    = val;
      REG_MIN_B:   floor_b   = val;
      REG_MAX_B:   ceil_b    = val;
      default: ;
    endcase
  endtask

  task automatic close_regs();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offers one request pair and waits for it to be taken. Valid is not
  // dropped after acceptance: the next call either changes the payload with
  // valid held high or lowers valid for a drawn gap.
  task automatic offer(in_req_t req, bit typed, out_req_t typed_rpt);
    int       gap;
    bit       closed;
    out_req_t rpt;
    gap = calm ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    absorb_pair(req, closed, rpt);
    if (closed) begin
      due_reports.push_back(typed ? typed_rpt : rpt);
    end
  endtask

  // Stops offering and waits until every owed report has come back, then
  // lets the block run quiet so that no division is still in progress.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Draws a calibration window: full scale, a random window, a crossed pair
  // or a window of zero width.
  task automatic pick_window(output logic [SAMPLE_W-1:0] lo,
                             output logic [SAMPLE_W-1:0] hi);
    case ($urandom_range(0, 3))
      0: begin
        lo = RST_LOW;
        hi = RST_HIGH;
      end
      1: begin
        lo = SAMPLE_W'($urandom_range(0, 500));
        hi = SAMPLE_W'($urandom_range(lo, 1023));
      end
      2: begin
        lo = SAMPLE_W'($urandom_range(512, 1023));
        hi = SAMPLE_W'($urandom_range(0, 511));
      end
      default: begin
        lo = SAMPLE_W'($urandom_range(0, 1023));
        hi = lo;
      end
    endcase
  endtask

  function automatic logic [SAMPLE_W-1:0] near(int center);
    int v;
    v = center + $urandom_range(0, 80) - 40;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v[SAMPLE_W-1:0];
  endfunction

  // Sends one full group. Most groups have a clear stronger receiver so that
  // the hysteresis counter really walks; the rest are alike or pure noise.
  task automatic send_group(bit lean_b);
    int      pick;
    int      shape;
    int      ca;
    int      cb;
    in_req_t req;
    pick = $urandom_range(0, 99);
    if (lean_b && pick < 80) begin
      shape = SHAPE_A_WEAK;
    end else if (pick < 35) begin
      shape = SHAPE_A_WEAK;
    end else if (pick < 65) begin
      shape = SHAPE_A_STRONG;
    end else if (pick < 80) begin
      shape = SHAPE_ALIKE;
    end else begin
      shape = SHAPE_NOISE;
    end
    ca = $urandom_range(0, 1023);
    cb = ca;
    if (shape == SHAPE_A_WEAK) begin
      ca = $urandom_range(0, 400);
      cb = $urandom_range(500, 1023);
    end else if (shape == SHAPE_A_STRONG) begin
      ca = $urandom_range(500, 1023);
      cb = $urandom_range(0, 400);
    end
    repeat (GROUP_LEN) begin
      if (shape == SHAPE_NOISE) begin
        req.sample_a = SAMPLE_W'($urandom_range(0, 1023));
        req.sample_b = SAMPLE_W'($urandom_range(0, 1023));
      end else begin
        req.sample_a = near(ca);
        req.sample_b = near(cb);
      end
      offer(req, 1'b0, '0);
    end
  endtask

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      note_failure($sformatf("%s expected %0d, got %0d", name, want, got));
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver side. out_ready is recomputed at every falling edge: the long
  // hold-off has priority, then the short stall drawn for the next report.
  // --------------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_extra > 0) begin
        out_ready <= 1'b0;
        hold_extra--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Every accepted report is compared field by field with the oldest one
  // owed. A report with nothing owed is a failure on its own.
  always @(posedge clk) begin : check_reports
    out_req_t want;
    if (rst_n && out_valid && out_ready) begin
      stall_left = calm ? 0 : $urandom_range(0, 5);
      if (due_reports.size() == 0) begin
        note_failure($sformatf("report with none owed: averages %0d/%0d",
                               out_data.average_a, out_data.average_b));
      end else begin
        want = due_reports.pop_front();
        compare_field("average_a", want.average_a, out_data.average_a);
        compare_field("average_b", want.average_b, out_data.average_b);
        compare_field("level_a", want.level_a, out_data.level_a);
        compare_field("level_b", want.level_b, out_data.level_b);
        compare_field("percent_diff", want.percent_diff, out_data.percent_diff);
        compare_field("active_receiver", want.active_receiver,
                      out_data.active_receiver);
        compare_field("led_a", want.led_a, out_data.led_a);
        compare_field("led_b", want.led_b, out_data.led_b);
      end
    end
  end

  // Hang detection: any accepted request on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    step_row_t           plan[$];
    bit                  regs_open;
    bit                  pairs_open;
    int                  r;
    logic [SAMPLE_W-1:0] lo_pick;
    logic [SAMPLE_W-1:0] hi_pick;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_MODE;
    cfg_wdata = '0;

    // Predictor starts from the reset state of the block.
    mode_sel  = RST_MODE;
    cut_pct   = RST_CUTOVER;
    check_max = RST_CHECKS;
    fill      = '0;
    acc_a     = '0;
    acc_b     = '0;
    floor_a   = RST_LOW;
    ceil_a    = RST_HIGH;
    floor_b   = RST_LOW;
    ceil_b    = RST_HIGH;
    tally     = '0;
    chosen    = SEL_NONE;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. The first group runs on reset settings with A at full
    // scale and B at zero: A is far stronger, so A is picked and the percent
    // difference saturates.
    plan.push_back('{STEP_PAIRS, REG_MODE, '0, '{10'd1023, 10'd0}, 4'd8, 1'b1,
                     '{10'd1023, 10'd0, 7'd100, 7'd1, 8'd255, SEL_A, 1'b1, 1'b0}});
    // Zero-width window on A and crossed limits on B; both read as level one.
    // Forcing B must light B with a zero percent field.
    plan.push_back('{STEP_WRITE, REG_MIN_A, 10'd300, '0, 4'd0, 1'b0, '0});
    plan.push_back('{STEP_WRITE, REG_MAX_A, 10'd300, '0, 4'd0, 1'b0, '0});
    plan.push_back('{STEP_WRITE, REG_MIN_B, 10'd1023, '0, 4'd0, 1'b0, '0});
    plan.push_back('{STEP_WRITE, REG_MAX_B, 10'd0, '0, 4'd0, 1'b0, '0});
    plan.push_back('{STEP_WRITE, REG_MODE, CFG_DATA_W'(MODE_FORCE_B), '0, 4'd0, 1'b0,
                     '0});
    plan.push_back('{STEP_PAIRS, REG_MODE, '0, '{10'd300, 10'd0}, 4'd4, 1'b0, '0});
    plan.push_back('{STEP_PAIRS, REG_MODE, '0, '{10'd300, 10'd1023}, 4'd4, 1'b1,
                     '{10'd300, 10'd511, 7'd1, 7'd1, 8'd0, SEL_B, 1'b0, 1'b1}});
    // Back to automatic with a maximum of zero checks and no cutover: B is
    // stronger but the counter cannot climb, so A is selected.
    plan.push_back('{STEP_WRITE, REG_MODE, CFG_DATA_W'(MODE_AUTO), '0, 4'd0, 1'b0,
                     '0});
    plan.push_back('{STEP_WRITE, REG_CUTOVER, 10'd0, '0, 4'd0, 1'b0, '0});
    plan.push_back('{STEP_WRITE, REG_CHECKS, 10'd0, '0, 4'd0, 1'b0, '0});
    plan.push_back('{STEP_WRITE, REG_MIN_A, RST_LOW, '0, 4'd0, 1'b0, '0});
    plan.push_back('{STEP_WRITE, REG_MAX_A, RST_HIGH, '0, 4'd0, 1'b0, '0});
    plan.push_back('{STEP_WRITE, REG_MIN_B, RST_LOW, '0, 4'd0, 1'b0, '0});
    plan.push_back('{STEP_WRITE, REG_MAX_B, RST_HIGH, '0, 4'd0, 1'b0, '0});
    plan.push_back('{STEP_PAIRS, REG_MODE, '0, '{10'd0, 10'd1023}, 4'd8, 1'b1,
                     '{10'd0, 10'd1023, 7'd1, 7'd100, 8'd99, SEL_A, 1'b1, 1'b0}});

    regs_open  = 1'b0;
    pairs_open = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].kind == STEP_WRITE) begin
        // Registers change only once the block has gone quiet.
        if (pairs_open) settle();
        pairs_open = 1'b0;
        write_reg(plan[i].reg_idx, plan[i].reg_val);
        regs_open = 1'b1;
      end else begin
        if (regs_open) close_regs();
        regs_open = 1'b0;
        repeat (plan[i].reps - 1) offer(plan[i].pair, 1'b0, '0);
        offer(plan[i].pair, plan[i].typed, plan[i].want);
        pairs_open = 1'b1;
      end
    end

    // Random part, in phases. Each phase starts with the sender paused until
    // every owed report has come back, then reprograms some registers.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      case (phase)
        0: begin
          // Large maximum and no cutover: the counter climbs toward B.
          write_reg(REG_MODE, CFG_DATA_W'(MODE_AUTO));
          write_reg(REG_CUTOVER, 10'd0);
          write_reg(REG_CHECKS, 10'd255);
          write_reg(REG_MIN_A, RST_LOW);
          write_reg(REG_MAX_A, RST_HIGH);
          write_reg(REG_MIN_B, RST_LOW);
          write_reg(REG_MAX_B, RST_HIGH);
        end
        1: begin
          // Maximum drops under the climbed counter; B must be reported.
          write_reg(REG_CHECKS, 10'd1);
        end
        2: begin
          write_reg(REG_MODE, CFG_DATA_W'(MODE_SPARE));
        end
        3: begin
          write_reg(REG_MODE, CFG_DATA_W'(MODE_AUTO));
          write_reg(REG_CUTOVER, 10'd255);
          write_reg(REG_CHECKS, CFG_DATA_W'($urandom_range(1, 8)));
        end
        4: begin
          write_reg(REG_MODE, CFG_DATA_W'(MODE_FORCE_A));
        end
        default: begin
          r = $urandom_range(0, 9);
          write_reg(REG_MODE, CFG_DATA_W'((r < 6 || r == 9) ? MODE_AUTO :
                                          (r == 6) ? MODE_FORCE_A :
                                          (r == 7) ? MODE_FORCE_B : MODE_SPARE));
          write_reg(REG_CUTOVER, CFG_DATA_W'(($urandom_range(0, 3) == 0) ?
                                 $urandom_range(0, 255) : $urandom_range(0, 40)));
          write_reg(REG_CHECKS, CFG_DATA_W'(($urandom_range(0, 3) == 0) ?
                                $urandom_range(0, 255) : $urandom_range(0, 6)));
          if ($urandom_range(0, 1) == 1) begin
            pick_window(lo_pick, hi_pick);
            write_reg(REG_MIN_A, lo_pick);
            write_reg(REG_MAX_A, hi_pick);
            pick_window(lo_pick, hi_pick);
            write_reg(REG_MIN_B, lo_pick);
            write_reg(REG_MAX_B, hi_pick);
          end
        end
      endcase
      close_regs();

      // Some phases run without any idling on either side; the pressure
      // phase also holds the receiver off while the sender keeps offering.
      calm = (phase % 4 == 3) || (phase == PRESSURE_PHASE);
      if (phase == PRESSURE_PHASE) begin
        @(posedge clk);
        hold_extra = LONG_HOLD;
      end
      repeat (GROUPS_PER_PHASE) send_group(phase == 0);
    end

    settle();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
